@@ design/cpak_pkg.sv @@
// cpak_pkg: shared types, constants and the crc-8 step for the controller pak store
// no dependencies; imported by controller_pak_store_with_crc and cpak_checker
package cpak_pkg;

  localparam int STORE_BYTES = 32768;
  localparam int BLOCK_BYTES = 32;
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  localparam int BLK_W       = $clog2(BLOCK_BYTES);

  localparam logic [7:0] CRC_POLY    = 8'h85;
  localparam logic [7:0] RUMBLE_FILL = 8'h80;

  localparam logic [1:0] KIND_NONE   = 2'd0;
  localparam logic [1:0] KIND_MEMPAK = 2'd1;
  localparam logic [1:0] KIND_RUMBLE = 2'd2;

  localparam logic FUNC_READ  = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;

  typedef struct packed {
    logic        func;
    logic [15:0] block_address;
    logic [4:0]  byte_position;
    logic [7:0]  write_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_last;
  } out_item_t;

  // one data byte into the crc register, msb first
  function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    logic       fb;
    c = crc;
    for (int j = 7; j >= 0; j--) begin
      fb = c[7];
      c  = {c[6:0], data[j]};
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

endpackage

@@ design/cpak_ram.sv @@
// cpak_ram: simple dual-port synchronous ram, one write and one registered read port
// no dependencies; read data holds when no read is issued
module cpak_ram #(
  parameter int ADDR_W = 15,
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/controller_pak_store_with_crc.sv @@
// controller_pak_store_with_crc: top level, byte store sequencer with crc-8 on reads and writes
// depends on cpak_pkg and cpak_ram
//
// After reset the block clears all 32768 bytes (STORE_BYTES) of the store, one byte a cycle,
// with in_stall high; configuration writes are taken during it. A write item writes the
// store directly when the kind is mempak and the block is in range; the byte at position
// 31 puts its crc item in the output register in the same cycle. A read item streams 32
// data items and a crc item at one item per cycle while the output is not stalled, each
// data byte passing the store's read register and then the output register, and holds the
// input until its crc item is loaded. The rate is set by the single read port of the store.
module controller_pak_store_with_crc
  import cpak_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item,
  input  logic      cfg_we,
  input  logic [1:0] cfg_data
);

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_READ  = 3'b100
  } state_t;

  typedef enum logic [1:0] {
    SRC_ZERO = 2'd0,
    SRC_MEM  = 2'd1,
    SRC_FILL = 2'd2
  } src_t;

  state_t                   state;
  logic [ADDR_W-1:0]        clr_addr;
  logic [1:0]               kind;
  logic [7:0]               running_crc;
  logic [7:0]               rd_crc;
  logic [ADDR_W-BLK_W-1:0]  rd_base;
  src_t                     rd_src;
  logic [BLK_W:0]           issue_cnt;
  logic [BLK_W:0]           load_cnt;
  logic                     rd_pending;

  logic              out_free;
  logic              in_acc;
  logic [15:0]       aligned;
  logic              in_range;
  logic              load_data;
  logic              issue;
  logic              load_crc;
  logic [7:0]        rd_byte;
  logic [7:0]        mem_q;
  logic [7:0]        wr_crc;
  src_t              src_next;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [7:0]        mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;

  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = !((state == S_IDLE) && out_free);
  assign in_acc    = in_valid && !in_stall;
  assign aligned   = {in_item.block_address[15:BLK_W], BLK_W'(0)};
  assign in_range  = ({1'b0, aligned} + 17'(BLOCK_BYTES)) <= 17'(STORE_BYTES);

  // data byte waits in the ram output register until the output register takes it
  assign load_data = (state == S_READ) && rd_pending && out_free;
  assign issue     = (state == S_READ) && (issue_cnt != (BLK_W+1)'(BLOCK_BYTES))
                     && (!rd_pending || load_data);
  assign load_crc  = (state == S_READ) && (load_cnt == (BLK_W+1)'(BLOCK_BYTES)) && out_free;

  assign wr_crc = crc_byte((in_item.byte_position == '0) ? 8'h00 : running_crc,
                           in_item.write_byte);

  always_comb begin
    case (rd_src)
      SRC_MEM:  rd_byte = mem_q;
      SRC_FILL: rd_byte = RUMBLE_FILL;
      default:  rd_byte = 8'h00;
    endcase
  end

  always_comb begin
    if (kind == KIND_MEMPAK && in_range) begin
      src_next = SRC_MEM;
    end else if (kind == KIND_RUMBLE) begin
      src_next = SRC_FILL;
    end else begin
      src_next = SRC_ZERO;
    end
  end

  assign mem_we = (state == S_CLEAR)
                  || (in_acc && in_item.func == FUNC_WRITE && kind == KIND_MEMPAK && in_range);
  assign mem_waddr = (state == S_CLEAR) ? clr_addr
                     : {aligned[ADDR_W-1:BLK_W], in_item.byte_position};
  assign mem_wdata = (state == S_CLEAR) ? 8'h00 : in_item.write_byte;
  assign mem_raddr = {rd_base, issue_cnt[BLK_W-1:0]};

  cpak_ram #(
    .ADDR_W (ADDR_W),
    .DATA_W (8)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (issue),
    .raddr (mem_raddr),
    .rdata (mem_q)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_addr    <= '0;
      kind        <= KIND_MEMPAK;
      running_crc <= 8'h00;
      issue_cnt   <= '0;
      load_cnt    <= '0;
      rd_pending  <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        kind <= cfg_data;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == '1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            if (in_item.func == FUNC_READ) begin
              state     <= S_READ;
              issue_cnt <= '0;
              load_cnt  <= '0;
            end else begin
              running_crc <= wr_crc;
            end
          end
        end
        S_READ: begin
          if (issue) begin
            issue_cnt <= issue_cnt + 1'b1;
          end
          if (load_data) begin
            load_cnt <= load_cnt + 1'b1;
          end
          rd_pending <= issue || (rd_pending && !load_data);
          if (load_crc) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_CLEAR;
        end
      endcase

      if (load_data || load_crc
          || (in_acc && in_item.func == FUNC_WRITE
              && in_item.byte_position == 5'(BLOCK_BYTES - 1))) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_acc && in_item.func == FUNC_READ) begin
      rd_base <= aligned[ADDR_W-1:BLK_W];
      rd_src  <= src_next;
      rd_crc  <= 8'h00;
    end else if (load_data) begin
      rd_crc <= crc_byte(rd_crc, rd_byte);
    end

    if (load_data) begin
      out_item.out_byte <= rd_byte;
      out_item.is_last  <= 1'b0;
    end else if (load_crc) begin
      out_item.out_byte <= crc_byte(rd_crc, 8'h00);
      out_item.is_last  <= 1'b1;
    end else if (in_acc && in_item.func == FUNC_WRITE) begin
      // only shown when the block is complete
      out_item.out_byte <= crc_byte(wr_crc, 8'h00);
      out_item.is_last  <= 1'b1;
    end
  end

endmodule

@@ design/cpak_checker.sv @@
// cpak_checker: port-level assertions for controller_pak_store_with_crc, bound to the top
// depends on cpak_pkg
module cpak_checker
  import cpak_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_item,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_item
);

  logic in_acc;
  assign in_acc = in_valid && !in_stall;

  // a stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled output item changed");

  // clearing pass keeps the input closed right after reset
  a_clear_stall: assert property (@(posedge clk)
    rst |=> in_stall)
    else $error("input open right after reset");

  // a write byte inside a block makes no result
  a_write_quiet: assert property (@(posedge clk) disable iff (rst)
    in_acc && in_item.func == FUNC_WRITE
    && in_item.byte_position != 5'(BLOCK_BYTES - 1) |=> !out_valid)
    else $error("result after a mid-block write");

  // the last write byte yields its crc item at once
  a_write_crc: assert property (@(posedge clk) disable iff (rst)
    in_acc && in_item.func == FUNC_WRITE
    && in_item.byte_position == 5'(BLOCK_BYTES - 1) |=> out_valid && out_item.is_last)
    else $error("missing crc item after last write byte");

  // a read goes through the store, so nothing shows the next cycle
  a_read_latency: assert property (@(posedge clk) disable iff (rst)
    in_acc && in_item.func == FUNC_READ |=> !out_valid && in_stall)
    else $error("read result too early");

endmodule

bind controller_pak_store_with_crc cpak_checker u_cpak_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

@@ sim/pak_tb_pkg.sv @@
// pak_tb_pkg: scoreboard for the controller pak store, with its own copy of the byte store,
// the write crc and the accessory kind; depends on cpak_pkg for item types and constants
package pak_tb_pkg;
  import cpak_pkg::*;

  localparam logic [1:0] KIND_SPARE = 2'd3;
  localparam logic [4:0] LAST_POS   = 5'(BLOCK_BYTES - 1);

  class pak_scoreboard;
    logic [7:0] image [STORE_BYTES];
    logic [7:0] write_crc;
    logic [1:0] kind;
    out_item_t  expected_q [$];
    int         errors;

    function new();
      foreach (image[i]) image[i] = 8'h00;
      write_crc = 8'h00;
      kind      = KIND_MEMPAK;
      errors    = 0;
    endfunction

    function void set_kind(logic [1:0] k);
      kind = k;
    endfunction

    // shift one byte through the crc register, msb first
    function logic [7:0] crc_shift(logic [7:0] acc, logic [7:0] data);
      logic [7:0] r;
      logic       top;
      r = acc;
      for (int i = 7; i >= 0; i--) begin
        top = r[7];
        r   = {r[6:0], data[i]} ^ (top ? CRC_POLY : 8'h00);
      end
      return r;
    endfunction

    function void note_input(in_item_t it);
      int unsigned base;
      logic [7:0]  d;
      logic [7:0]  acc;
      bit          in_range;
      out_item_t   e;
      base     = {it.block_address[15:5], 5'b00000};
      in_range = (base + BLOCK_BYTES <= STORE_BYTES);
      if (it.func == FUNC_READ) begin
        acc = 8'h00;
        for (int k = 0; k < BLOCK_BYTES; k++) begin
          case (kind)
            KIND_MEMPAK: d = in_range ? image[base + k] : 8'h00;
            KIND_RUMBLE: d = RUMBLE_FILL;
            default:     d = 8'h00;
          endcase
          acc        = crc_shift(acc, d);
          e.out_byte = d;
          e.is_last  = 1'b0;
          expected_q.push_back(e);
        end
        // eight zero bits appended after the data
        e.out_byte = crc_shift(acc, 8'h00);
        e.is_last  = 1'b1;
        expected_q.push_back(e);
      end else begin
        if (kind == KIND_MEMPAK && in_range) begin
          image[base + it.byte_position] = it.write_byte;
        end
        write_crc = crc_shift((it.byte_position == 5'd0) ? 8'h00 : write_crc, it.write_byte);
        if (it.byte_position == LAST_POS) begin
          e.out_byte = crc_shift(write_crc, 8'h00);
          e.is_last  = 1'b1;
          expected_q.push_back(e);
        end
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: item with none expected: out_byte %02h is_last %0b",
                 $time, got.out_byte, got.is_last);
      end else begin
        want = expected_q.pop_front();
        if (got.out_byte !== want.out_byte) begin
          errors++;
          $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                   $time, want.out_byte, got.out_byte);
        end
        if (got.is_last !== want.is_last) begin
          errors++;
          $display("%0t: is_last mismatch: expected %0b, actual %0b",
                   $time, want.is_last, got.is_last);
        end
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

endpackage

@@ sim/tb_top.sv @@
// tb_top: drives reads, write blocks and accessory changes into controller_pak_store_with_crc
// and checks every output item against pak_scoreboard; depends on cpak_pkg and pak_tb_pkg
module tb_top;
  import cpak_pkg::*;
  import pak_tb_pkg::*;

  localparam int WATCHDOG_CYCLES = 150000;
  localparam int SETTLE_CYCLES   = 40;
  localparam int HOLD_CYCLES     = 400;

  logic      clk = 1'b0;
  logic      rst;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;
  logic      cfg_we;
  logic [1:0] cfg_data;

  int sender_pct;
  int stall_pct;
  bit hold_req;
  int quiet_cycles;

  pak_scoreboard sb;

  controller_pak_store_with_crc u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // accepted items on both sides, plus the watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        sb.note_input(in_item);
      end
      if (out_valid && !out_stall) begin
        sb.check_result(out_item);
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_CYCLES) begin
        $display("watchdog: no item moved for %0d cycles", WATCHDOG_CYCLES);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // receiver: random stalls, or one long hold when asked
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        out_stall = ($urandom_range(99) < stall_pct);
      end
    end
  end

  function automatic in_item_t make_item(logic f, logic [15:0] addr, logic [4:0] pos,
                                         logic [7:0] data);
    in_item_t it;
    it.func          = f;
    it.block_address = addr;
    it.byte_position = pos;
    it.write_byte    = data;
    return it;
  endfunction

  // mostly a few blocks that get reused, some out of range, some anywhere
  function automatic logic [15:0] pick_block();
    int r;
    r = $urandom_range(99);
    if (r < 70) begin
      case ($urandom_range(5))
        0:       return 16'h0000;
        1:       return 16'h0020;
        2:       return 16'h1240;
        3:       return 16'h4000;
        4:       return 16'h7FC0;
        default: return 16'h7FE0;
      endcase
    end else if (r < 85) begin
      return 16'h8000 | 16'($urandom_range(16'h7FFF));
    end else begin
      return 16'($urandom());
    end
  endfunction

  function automatic logic [15:0] with_low_bits(logic [15:0] base);
    return {base[15:5], 5'($urandom_range(31))};
  endfunction

  // starts after a rising edge, returns at the edge that accepts the item
  task automatic offer_item(input in_item_t it);
    @(negedge clk);
    while ($urandom_range(99) < sender_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_item  = it;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic wait_idle();
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_kind(input logic [1:0] k);
    @(negedge clk);
    cfg_we   = 1'b1;
    cfg_data = k;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.set_kind(k);
  endtask

  task automatic random_read();
    offer_item(make_item(FUNC_READ, with_low_bits(pick_block()), 5'($urandom_range(31)),
                         8'($urandom_range(255))));
  endtask

  task automatic run_random(input int n);
    int          sent;
    int          sel;
    int          stop;
    logic [15:0] base;
    sent = 0;
    while (sent < n) begin
      sel = $urandom_range(99);
      if (sel < 40) begin
        random_read();
        sent++;
      end else if (sel < 85) begin
        // a block of write items, now and then cut short
        base = pick_block();
        stop = ($urandom_range(9) == 0) ? $urandom_range(30) : BLOCK_BYTES - 1;
        // keep the block within the items left for this run
        if (stop > n - sent - 1) begin
          stop = n - sent - 1;
        end
        for (int p = 0; p <= stop; p++) begin
          offer_item(make_item(FUNC_WRITE, with_low_bits(base), 5'(p),
                               8'($urandom_range(255))));
        end
        sent += stop + 1;
      end else begin
        offer_item(make_item(FUNC_WRITE, 16'($urandom()), 5'($urandom_range(31)),
                             8'($urandom_range(255))));
        sent++;
      end
    end
  endtask

  initial begin
    sb           = new();
    rst          = 1'b1;
    in_valid     = 1'b0;
    in_item      = '0;
    cfg_we       = 1'b0;
    cfg_data     = KIND_MEMPAK;
    sender_pct   = 0;
    stall_pct    = 0;
    hold_req     = 1'b0;
    quiet_cycles = 0;
    repeat (12) @(negedge clk);
    rst = 1'b0;

    // taken while the store is being cleared
    write_kind(KIND_MEMPAK);

    offer_item(make_item(FUNC_READ,  16'h0000, 5'd0,  8'h00));
    offer_item(make_item(FUNC_READ,  16'hFFFF, 5'd31, 8'hFF));
    offer_item(make_item(FUNC_WRITE, 16'h7FE0, 5'd0,  8'hFF));
    offer_item(make_item(FUNC_WRITE, 16'h7FFF, 5'd1,  8'h00));
    offer_item(make_item(FUNC_WRITE, 16'h7FE0, LAST_POS, 8'hA5));
    // crc keeps running with no restart at position zero
    offer_item(make_item(FUNC_WRITE, 16'h0000, LAST_POS, 8'h5A));
    offer_item(make_item(FUNC_READ,  16'h7FE0, 5'd0,  8'h00));
    offer_item(make_item(FUNC_WRITE, 16'h8000, 5'd0,  8'h3C));
    offer_item(make_item(FUNC_WRITE, 16'hFFE0, LAST_POS, 8'hC3));
    offer_item(make_item(FUNC_READ,  16'h8000, 5'd0,  8'h00));
    offer_item(make_item(FUNC_READ,  16'h7FE1, 5'd0,  8'h00));
    offer_item(make_item(FUNC_WRITE, 16'h1234, 5'd16, 8'h55));
    offer_item(make_item(FUNC_WRITE, 16'h123F, LAST_POS, 8'hAA));
    offer_item(make_item(FUNC_READ,  16'h1220, 5'd0,  8'h00));
    wait_idle();

    run_random(40);
    // output held off while reads keep coming, so the input backs up
    hold_req = 1'b1;
    repeat (8) random_read();
    wait_idle();

    sender_pct = 48;
    run_random(20);
    wait_results();
    run_random(20);
    wait_idle();

    sender_pct = 0;
    stall_pct  = 48;
    run_random(40);
    wait_idle();

    sender_pct = 11;
    stall_pct  = 11;
    run_random(40);
    wait_idle();

    write_kind(KIND_RUMBLE);
    offer_item(make_item(FUNC_READ,  16'h0000, 5'd0,  8'h00));
    offer_item(make_item(FUNC_READ,  16'hFFE0, 5'd0,  8'h00));
    offer_item(make_item(FUNC_WRITE, 16'h0020, 5'd0,  8'h11));
    offer_item(make_item(FUNC_WRITE, 16'h0020, LAST_POS, 8'h22));
    run_random(8);
    wait_idle();

    write_kind(KIND_NONE);
    offer_item(make_item(FUNC_READ,  16'h7FE0, 5'd0,  8'h00));
    offer_item(make_item(FUNC_WRITE, 16'h0000, LAST_POS, 8'h99));
    run_random(8);
    wait_idle();

    write_kind(KIND_SPARE);
    offer_item(make_item(FUNC_READ, 16'h0000, 5'd0, 8'h00));
    run_random(6);
    wait_idle();

    sender_pct = 0;
    stall_pct  = 0;
    write_kind(KIND_MEMPAK);
    offer_item(make_item(FUNC_READ, 16'h0020, 5'd0, 8'h00));
    offer_item(make_item(FUNC_READ, 16'h0000, 5'd0, 8'h00));
    run_random(15);
    wait_idle();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
